// ===== hdl/sog_pkg.sv =====
// Shared types and codes for the slot offset gap adjuster.
// Used by sog_div, sog_ctrl, sog_datapath and the top level.
`default_nettype none
package sog_pkg;

	localparam logic [1:0] FUNC_CLEAR  = 2'd0;
	localparam logic [1:0] FUNC_ADD    = 2'd1;
	localparam logic [1:0] FUNC_EVAL   = 2'd2;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	localparam logic [1:0] DIV_CLAIM = 2'd0;
	localparam logic [1:0] DIV_OWN   = 2'd1;
	localparam logic [1:0] DIV_TIME  = 2'd2;

	localparam logic [1:0] RD_K    = 2'd0;
	localparam logic [1:0] RD_J    = 2'd1;
	localparam logic [1:0] RD_ZERO = 2'd2;

	localparam logic [15:0] IV_RESET = 16'd128;
	localparam logic [15:0] IV_MIN   = 16'd2;
	localparam logic [14:0] CLAIM_SAT = 15'h7fff;

	typedef struct packed {
		logic       clear;
		logic       add;
		logic       load_own;
		logic       div_go;
		logic [1:0] div_sel;
		logic       st_claim;
		logic       st_own;
		logic       st_off;
		logic       k_clr;
		logic       k_inc;
		logic       j_clr;
		logic       j_inc;
		logic       rd_time;
		logic       rd_off;
		logic [1:0] rd_sel;
		logic       st_first;
		logic       st_ok;
		logic       upd_nd;
		logic       upd_gap;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic k_last;
		logic j_last;
		logic cnt_zero;
		logic cnt_lt2;
		logic keep;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

// ===== hdl/slot_offset_gap_adjuster.sv =====
// Top level of the slot offset gap adjuster: controller plus datapath.
// Depends on sog_pkg, sog_ctrl, sog_datapath (and sog_div below it).
//
// Channel   Direction  Payload
// s_*       in         tuser: func; tdata: beacon_time, own_offset
// m_*       out        tdata: new_offset, moved, claim_ticks, share_ticks, overflow
// cfg_*     in         cfg_data: interval_ticks
//
// Clear and add items are handled in the idle state without leaving it.
// Evaluate with n neighbors runs 16-bit divides for the claim, the own offset and each
// neighbor offset; with an empty list the neighbor divides are skipped. When the offset
// is moved and n >= 2, a pairwise gap search follows.
// arst_n clears the list count, overflow flag, interval (to 128) and controller.
// A stalled result holds in the output register; clear and add still go through.
`default_nettype none
module slot_offset_gap_adjuster import sog_pkg::*; #(
	parameter int MAX_NEIGHBOR_ENTRIES = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // beacon_time[15:0], own_offset[31:16]
	input  wire logic [1:0]  s_tuser,   // func[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// new_offset[15:0], moved[16], claim_ticks[31:17], share_ticks[47:32],
	// overflow[48], zero fill[55:49]
	output logic [55:0]      m_tdata,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data
);
	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	sog_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_func (s_tuser),
		.in_ready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	sog_datapath #(
		.MAX_NEIGHBOR_ENTRIES(MAX_NEIGHBOR_ENTRIES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.beacon_time(s_tdata[15:0]),
		.own_offset (s_tdata[31:16]),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);
endmodule
`default_nettype wire

// ===== hdl/sog_div.sv =====
// Restoring 16-bit divider, one quotient bit per cycle.
// Depends on sog_pkg; used by sog_datapath for claim and modulo operations.
`default_nettype none
module sog_div import sog_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [15:0] dividend,
	input  wire logic [15:0] divisor,
	output logic             busy,
	output logic [15:0]      quotient,
	output logic [15:0]      remainder
);
	logic [15:0] rem_q, quo_q, dvs_q;
	logic [4:0]  cnt_q;
	logic [16:0] trial;
	logic        fits;

	assign trial = {rem_q, quo_q[15]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 5'd16;
		end else if (cnt_q != 5'd0) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != 5'd0) begin
			rem_q <= fits ? 16'(trial - {1'b0, dvs_q}) : trial[15:0];
			quo_q <= {quo_q[14:0], fits};
		end
	end

	assign busy      = cnt_q != 5'd0;
	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule
`default_nettype wire

// ===== hdl/sog_ctrl.sv =====
// Sequencer for list updates and the evaluate walk.
// Depends on sog_pkg; drives sog_datapath through cmd_t and reads sts_t.
`default_nettype none
module sog_ctrl import sog_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [1:0] in_func,
	output logic            in_ready,
	input  wire sts_t       sts,
	output cmd_t            cmd
);
	typedef enum logic [15:0] {
		S_IDLE    = 16'h0001,
		S_CLAIM   = 16'h0002,
		S_CLAIM_W = 16'h0004,
		S_OWN     = 16'h0008,
		S_OWN_W   = 16'h0010,
		S_TRD     = 16'h0020,
		S_TDIV    = 16'h0040,
		S_TDIV_W  = 16'h0080,
		S_DECIDE  = 16'h0100,
		S_FIRST   = 16'h0200,
		S_PK      = 16'h0400,
		S_PKW     = 16'h0800,
		S_PJ      = 16'h1000,
		S_PJW     = 16'h2000,
		S_PEND    = 16'h4000,
		S_FINISH  = 16'h8000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = state_q == S_IDLE;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.clear = in_func == FUNC_CLEAR;
					cmd.add   = in_func == FUNC_ADD;
					if (in_func == FUNC_EVAL) begin
						cmd.load_own = 1'b1;
						state_d      = S_CLAIM;
					end
				end
			end
			S_CLAIM: begin
				cmd.div_go  = 1'b1;
				cmd.div_sel = DIV_CLAIM;
				state_d     = S_CLAIM_W;
			end
			S_CLAIM_W: begin
				if (!sts.div_busy) begin
					cmd.st_claim = 1'b1;
					state_d      = S_OWN;
				end
			end
			S_OWN: begin
				cmd.div_go  = 1'b1;
				cmd.div_sel = DIV_OWN;
				state_d     = S_OWN_W;
			end
			S_OWN_W: begin
				if (!sts.div_busy) begin
					cmd.st_own = 1'b1;
					cmd.k_clr  = 1'b1;
					state_d    = sts.cnt_zero ? S_FINISH : S_TRD;
				end
			end
			S_TRD: begin
				cmd.rd_time = 1'b1;
				state_d     = S_TDIV;
			end
			S_TDIV: begin
				cmd.div_go  = 1'b1;
				cmd.div_sel = DIV_TIME;
				state_d     = S_TDIV_W;
			end
			S_TDIV_W: begin
				if (!sts.div_busy) begin
					cmd.st_off = 1'b1;
					if (sts.k_last) begin
						state_d = S_DECIDE;
					end else begin
						cmd.k_inc = 1'b1;
						state_d   = S_TRD;
					end
				end
			end
			S_DECIDE: begin
				if (sts.keep) begin
					state_d = S_FINISH;
				end else begin
					cmd.rd_off = 1'b1;
					cmd.rd_sel = RD_ZERO;
					state_d    = S_FIRST;
				end
			end
			S_FIRST: begin
				cmd.st_first = 1'b1;
				cmd.k_clr    = 1'b1;
				state_d      = sts.cnt_lt2 ? S_FINISH : S_PK;
			end
			S_PK: begin
				cmd.rd_off = 1'b1;
				cmd.rd_sel = RD_K;
				cmd.j_clr  = 1'b1;
				state_d    = S_PKW;
			end
			S_PKW: begin
				cmd.st_ok = 1'b1;
				state_d   = S_PJ;
			end
			S_PJ: begin
				cmd.rd_off = 1'b1;
				cmd.rd_sel = RD_J;
				state_d    = S_PJW;
			end
			S_PJW: begin
				cmd.upd_nd = 1'b1;
				if (sts.j_last) begin
					state_d = S_PEND;
				end else begin
					cmd.j_inc = 1'b1;
					state_d   = S_PJ;
				end
			end
			S_PEND: begin
				cmd.upd_gap = 1'b1;
				if (sts.k_last) begin
					state_d = S_FINISH;
				end else begin
					cmd.k_inc = 1'b1;
					state_d   = S_PK;
				end
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule
`default_nettype wire

// ===== hdl/sog_datapath.sv =====
// Neighbor list, offset store, divider, gap search registers and result register.
// Depends on sog_pkg and sog_div; commanded by sog_ctrl.
`default_nettype none
module sog_datapath import sog_pkg::*; #(
	parameter int MAX_NEIGHBOR_ENTRIES = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	output sts_t             sts,
	input  wire logic [15:0] beacon_time,
	input  wire logic [15:0] own_offset,
	input  wire logic        cfg_valid,
	input  wire logic [15:0] cfg_data,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [55:0]      m_tdata
);
	localparam int AW = (MAX_NEIGHBOR_ENTRIES > 1) ? $clog2(MAX_NEIGHBOR_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_NEIGHBOR_ENTRIES + 1);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_NEIGHBOR_ENTRIES);

	logic [15:0]   interval_q, iv;
	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic [15:0]   time_mem [MAX_NEIGHBOR_ENTRIES];
	logic [15:0]   offs_mem [MAX_NEIGHBOR_ENTRIES];
	logic [15:0]   time_rd_q, offs_rd_q;
	logic [AW-1:0] k_q, j_q, rd_addr;
	logic [15:0]   own_q, own_m_q, claim_q, share_q;
	logic [15:0]   first_q, ok_q, nd_q, gstart_q;
	logic [16:0]   gsize_q;
	logic          nd_found_q;

	logic        div_busy;
	logic [15:0] div_a, div_b, div_quo, div_rem;
	logic [16:0] d_sum, d_dist, p_sum;
	logic [15:0] p_dist;
	logic [15:0] gs_start;
	logic [16:0] gs_size, mid_sum, end_sum, back_sum;
	logic [15:0] end_mod, mid_mod, back_mod, new_off;
	logic        keep;

	assign iv = (interval_q < IV_MIN) ? IV_MIN : interval_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= IV_RESET;
		end else if (cfg_valid) begin
			interval_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.clear) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.add) begin
			if (count_q < CNT_MAX) begin
				count_q <= count_q + CW'(1);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.add && count_q < CNT_MAX) begin
			time_mem[count_q[AW-1:0]] <= beacon_time;
		end
		if (cmd.rd_time) begin
			time_rd_q <= time_mem[k_q];
		end
	end

	always_comb begin
		unique case (cmd.rd_sel)
			RD_K:    rd_addr = k_q;
			RD_J:    rd_addr = j_q;
			default: rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.st_off) begin
			offs_mem[k_q] <= div_rem;
		end
		if (cmd.rd_off) begin
			offs_rd_q <= offs_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
			j_q <= '0;
		end else begin
			if (cmd.k_clr) begin
				k_q <= '0;
			end else if (cmd.k_inc) begin
				k_q <= k_q + AW'(1);
			end
			if (cmd.j_clr) begin
				j_q <= '0;
			end else if (cmd.j_inc) begin
				j_q <= j_q + AW'(1);
			end
		end
	end

	always_comb begin
		unique case (cmd.div_sel)
			DIV_CLAIM: begin
				div_a = iv;
				div_b = 16'(count_q) + 16'd1;
			end
			DIV_OWN: begin
				div_a = own_q;
				div_b = iv;
			end
			default: begin
				div_a = time_rd_q;
				div_b = iv;
			end
		endcase
	end

	sog_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_go),
		.dividend (div_a),
		.divisor  (div_b),
		.busy     (div_busy),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	// Forward distance from own offset to a fresh neighbor offset.
	assign d_sum  = {1'b0, div_rem} + {1'b0, iv} - {1'b0, own_m_q};
	assign d_dist = (d_sum >= {1'b0, iv}) ? d_sum - {1'b0, iv} : d_sum;

	// Forward distance from the outer offset to the inner one.
	assign p_sum  = {1'b0, offs_rd_q} + {1'b0, iv} - {1'b0, ok_q};
	assign p_dist = (p_sum >= {1'b0, iv}) ? 16'(p_sum - {1'b0, iv}) : p_sum[15:0];

	always_ff @(posedge clk) begin
		if (cmd.load_own) begin
			own_q <= own_offset;
		end
		if (cmd.st_claim) begin
			claim_q <= div_quo;
		end
		if (cmd.st_own) begin
			own_m_q <= div_rem;
			share_q <= iv;
		end else if (cmd.st_off && d_dist < {1'b0, share_q}) begin
			share_q <= d_dist[15:0];
		end
		if (cmd.st_first) begin
			first_q <= offs_rd_q;
			gsize_q <= '0;
		end else if (cmd.upd_gap && nd_found_q &&
				({1'b0, nd_q} > gsize_q ||
				({1'b0, nd_q} == gsize_q && ok_q < gstart_q))) begin
			gsize_q  <= {1'b0, nd_q};
			gstart_q <= ok_q;
		end
		if (cmd.st_ok) begin
			ok_q       <= offs_rd_q;
			nd_found_q <= 1'b0;
		end else if (cmd.upd_nd && p_dist != 16'd0 &&
				(!nd_found_q || p_dist < nd_q)) begin
			nd_q       <= p_dist;
			nd_found_q <= 1'b1;
		end
	end

	// A zero-size gap means all neighbors coincide: the whole period is the gap.
	assign gs_start = (gsize_q == 17'd0) ? first_q : gstart_q;
	assign gs_size  = (gsize_q == 17'd0) ? {1'b0, iv} : gsize_q;
	assign mid_sum  = {1'b0, gs_start} + {1'b0, gs_size[16:1]};
	assign mid_mod  = (mid_sum >= {1'b0, iv}) ? 16'(mid_sum - {1'b0, iv}) : mid_sum[15:0];
	assign end_sum  = {1'b0, gs_start} + gs_size;
	assign end_mod  = (end_sum >= {1'b0, iv}) ? 16'(end_sum - {1'b0, iv}) : end_sum[15:0];
	assign back_sum = {1'b0, end_mod} + {1'b0, iv} - {1'b0, claim_q};
	assign back_mod = (back_sum >= {1'b0, iv}) ? 16'(back_sum - {1'b0, iv}) : back_sum[15:0];

	assign keep    = count_q == '0 || share_q >= claim_q;
	assign new_off = keep ? own_q :
		(gs_size >= {claim_q, 1'b0}) ? mid_mod : back_mod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_tdata <= {7'd0, ovf_q, share_q,
				(claim_q > {1'b0, CLAIM_SAT}) ? CLAIM_SAT : claim_q[14:0],
				~keep, new_off};
		end
	end

	assign sts.div_busy = div_busy;
	assign sts.k_last   = (CW'(k_q) + CW'(1)) == count_q;
	assign sts.j_last   = (CW'(j_q) + CW'(1)) == count_q;
	assign sts.cnt_zero = count_q == '0;
	assign sts.cnt_lt2  = count_q < CW'(2);
	assign sts.keep     = keep;
	assign sts.out_free = !m_tvalid || m_tready;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_MAX) else $error("neighbor count beyond capacity");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid || m_tready)) else $error("result overwritten");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_go |-> !div_busy) else $error("divider restarted while busy");
	a_div_runs: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_go |=> div_busy) else $error("divider did not start");
endmodule
`default_nettype wire

// ===== dv/slot_offset_gap_adjuster_chk.sv =====
// Checker for the slot offset gap adjuster: watches the input, result and
// configuration channels, predicts each evaluate result and compares it.
// Depends on sog_pkg for the function codes.
`timescale 1ns / 1ps
module slot_offset_gap_adjuster_chk import sog_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [55:0] m_tdata,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          pending
);
	// Members run from the highest bit down, so new_offset lands in the lowest bits.
	typedef struct packed {
		logic        overflow;
		logic [15:0] share_ticks;
		logic [14:0] claim_ticks;
		logic        moved;
		logic [15:0] new_offset;
	} slot_result_t;

	logic [15:0] nbr_times[32];
	int unsigned nbr_count;
	logic ovf_flag;
	logic [15:0] interval_reg;
	slot_result_t expected_slots[$];

	assign pending = expected_slots.size();

	task automatic report(input string what, input int unsigned got, input int unsigned want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		fail_count++;
	endtask

	function automatic slot_result_t predict_slot(input logic [15:0] own);
		int unsigned iv, claim, share, own_m, d, n, t, sz, g_start, g_end, g_size, nxt;
		int unsigned offs[32];
		slot_result_t r;
		iv = (interval_reg < 2) ? 2 : interval_reg;
		n = nbr_count;
		claim = iv / (n + 1);
		own_m = own % iv;
		share = iv;
		for (int k = 0; k < n; k++) begin
			offs[k] = nbr_times[k] % iv;
			d = (offs[k] + iv - own_m) % iv;
			if (d < share)
				share = d;
		end
		r.new_offset = own;
		r.moved = 1'b0;
		if (n != 0 && share < claim) begin
			g_start = 0;
			g_end = 0;
			g_size = 0;
			if (n >= 2) begin
				for (int i = 1; i < n; i++)
					for (int j = i; j > 0 && offs[j-1] > offs[j]; j--) begin
						t = offs[j];
						offs[j] = offs[j-1];
						offs[j-1] = t;
					end
				for (int k = 0; k < n; k++) begin
					nxt = (k == n - 1) ? 0 : k + 1;
					sz = (offs[nxt] + iv - offs[k]) % iv;
					if (sz > g_size) begin
						g_start = offs[k];
						g_end = offs[nxt];
						g_size = sz;
					end
				end
			end
			if (g_size == 0) begin
				g_start = offs[0];
				g_end = offs[0] + iv;
				g_size = iv;
			end
			if (g_size >= 2 * claim)
				r.new_offset = 16'((g_start + g_size / 2) % iv);
			else
				r.new_offset = 16'((g_end + iv - claim) % iv);
			r.moved = 1'b1;
		end
		r.claim_ticks = (claim > 32767) ? 15'h7fff : claim[14:0];
		r.share_ticks = share[15:0];
		r.overflow = ovf_flag;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		slot_result_t got, want;
		if (!arst_n) begin
			nbr_count = 0;
			ovf_flag = 0;
			interval_reg = IV_RESET;
			fail_count = 0;
			expected_slots.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				interval_reg = cfg_data;
			if (m_tvalid && m_tready) begin
				got = m_tdata[48:0];
				if (expected_slots.size() == 0) begin
					report("unexpected result", 1, 0);
				end else begin
					want = expected_slots.pop_front();
					if (got.new_offset != want.new_offset)
						report("new_offset", got.new_offset, want.new_offset);
					if (got.moved != want.moved)
						report("moved", got.moved, want.moved);
					if (got.claim_ticks != want.claim_ticks)
						report("claim_ticks", got.claim_ticks, want.claim_ticks);
					if (got.share_ticks != want.share_ticks)
						report("share_ticks", got.share_ticks, want.share_ticks);
					if (got.overflow != want.overflow)
						report("overflow", got.overflow, want.overflow);
				end
			end
			if (s_tvalid && s_tready) begin
				case (s_tuser)
					FUNC_CLEAR: begin
						nbr_count = 0;
						ovf_flag = 0;
					end
					FUNC_ADD: begin
						if (nbr_count < 32) begin
							nbr_times[nbr_count] = s_tdata[15:0];
							nbr_count++;
						end else
							ovf_flag = 1;
					end
					FUNC_EVAL: expected_slots.push_back(predict_slot(s_tdata[31:16]));
					default: ;
				endcase
			end
		end
	end
endmodule

// ===== dv/slot_offset_gap_adjuster_tb.sv =====
// Testbench top for the slot offset gap adjuster: clock, reset, stimulus and
// verdict. Depends on sog_pkg, the block and slot_offset_gap_adjuster_chk.
`timescale 1ns / 1ps
module slot_offset_gap_adjuster_tb import sog_pkg::*;;
	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [31:0] s_tdata = 0;
	logic [1:0] s_tuser = 0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [55:0] m_tdata;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [15:0] cfg_data = 0;
	int fail_count, pending;
	int unsigned cycles = 0;
	bit hold_sink = 0;
	bit drain_fast = 0;

	always #5 clk = ~clk;

	slot_offset_gap_adjuster i_dut (.*);
	slot_offset_gap_adjuster_chk i_chk (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 25000000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Result side: random stalls, a long hold-off on request.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_sink || (!drain_fast && pick_gap() > 1))
				m_tready <= 0;
			else
				m_tready <= 1;
		end
	end

	// Valid stays high between back-to-back items and drops only for a gap.
	task automatic send_item(input logic [1:0] f, input logic [15:0] bt,
			input logic [15:0] own, input bit gaps);
		int unsigned g;
		g = gaps ? pick_gap() : 0;
		if (g != 0) begin
			s_tvalid <= 0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= f;
		s_tdata <= {own, bt};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic write_interval(input logic [15:0] v);
		s_tvalid <= 0;
		drain_fast = 1;
		while (pending != 0) @(posedge clk);
		repeat (1200) @(posedge clk);
		cfg_valid <= 1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		drain_fast = 0;
	endtask

	// A well-formed round: clear, n neighbor adds, then an evaluate.
	task automatic round(input logic [15:0] iv, input int unsigned n);
		logic [15:0] bt;
		send_item(FUNC_CLEAR, 16'($urandom), 16'($urandom), 1);
		for (int i = 0; i < n; i++) begin
			bt = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, iv));
			send_item(FUNC_ADD, bt, 16'($urandom), 1);
		end
		send_item(FUNC_EVAL, 16'($urandom),
			($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65534))
				: 16'($urandom_range(0, iv)), 1);
	endtask

	initial begin
		logic [15:0] ivs[6];
		logic [1:0] f;
		ivs = '{16'd0, 16'd2, 16'd100, 16'd1000, 16'hffff, 16'd128};
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: empty list, unused code, extremes, equal offsets, full list.
		send_item(FUNC_EVAL, 0, 16'd5, 0);
		send_item(FUNC_UNUSED, 16'hffff, 16'hffff, 0);
		send_item(FUNC_EVAL, 0, 16'd300, 0);
		send_item(FUNC_ADD, 16'd10, 0, 0);
		send_item(FUNC_EVAL, 0, 16'd9, 0);
		send_item(FUNC_ADD, 16'd138, 0, 0);
		send_item(FUNC_EVAL, 0, 16'd9, 0);
		send_item(FUNC_CLEAR, 0, 0, 0);
		send_item(FUNC_ADD, 16'hffff, 0, 0);
		send_item(FUNC_ADD, 16'd0, 0, 0);
		send_item(FUNC_ADD, 16'd64, 0, 0);
		send_item(FUNC_EVAL, 0, 16'hfffe, 0);
		send_item(FUNC_EVAL, 0, 16'd0, 0);
		send_item(FUNC_CLEAR, 0, 0, 0);
		for (int i = 0; i < 34; i++)
			send_item(FUNC_ADD, 16'(i * 4), 0, 0);
		send_item(FUNC_EVAL, 0, 16'd1, 0);

		// Long receiver hold-off while evaluates keep coming.
		hold_sink = 1;
		fork
			begin
				repeat (3000) @(posedge clk);
				hold_sink = 0;
			end
			for (int i = 0; i < 4; i++)
				send_item(FUNC_EVAL, 0, 16'($urandom_range(0, 127)), 0);
		join

		foreach (ivs[k]) begin
			write_interval(ivs[k]);
			for (int r = 0; r < 34; r++) begin
				round(ivs[k] < 2 ? 16'd2 : ivs[k],
					($urandom_range(0, 9) == 0) ? $urandom_range(20, 34)
						: $urandom_range(0, 6));
			end
			// Noise: random codes and fields.
			for (int i = 0; i < 60; i++) begin
				f = 2'($urandom_range(0, 3));
				send_item(f, 16'($urandom), 16'($urandom_range(0, 65534)), 1);
			end
		end

		s_tvalid <= 0;
		drain_fast = 1;
		while (pending != 0) @(posedge clk);
		repeat (1500) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
